### sv/assert_macros.svh
// Assertion helpers shared by the RTL. Empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check on every clock edge outside reset.
`define RUTD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define RUTD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define RUTD_ASSERT(name, clk, rst_n, prop, msg)
`define RUTD_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

### sv/rutd_pkg.sv
`timescale 1ns / 1ps
package rutd_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned COUNT_W  = 24;

  // Verdict arithmetic: 100000*d^2 <= 38416*t is scaled down by 16 to
  // 6250*d^2 <= 2401*t with t = 16N-29.
  localparam int unsigned DIFF_W = COUNT_W + 3;  // 3R - 2N + 1, two's complement
  localparam int unsigned MAG_W  = 20;           // |d| at or above 2^20 always rejects
  localparam int unsigned T_W    = COUNT_W + 4;  // 16N - 29
  localparam int unsigned K_L_W  = 13;
  localparam int unsigned K_R_W  = 12;
  localparam int unsigned P1_W   = MAG_W + K_L_W;
  localparam int unsigned RHS_W  = T_W + K_R_W;
  localparam int unsigned LHS_W  = P1_W + MAG_W;

  localparam logic [K_L_W-1:0] LHS_K   = K_L_W'(6250);
  localparam logic [K_R_W-1:0] RHS_K   = K_R_W'(2401);
  localparam logic [T_W-1:0]   T_BIAS  = T_W'(29);

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [COUNT_W-1:0]  count_t;

  typedef struct packed {
    sample_t sample;
    logic    last;
  } in_item_t;

  typedef struct packed {
    count_t run_count;
    count_t value_count;
    logic   accepted;
    logic   too_few;
  } out_item_t;

  // Totals of one finished sequence, handed from front to back.
  typedef struct packed {
    count_t runs;
    count_t values;
  } tally_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIFF = 5'b00010,
    S_MUL1 = 5'b00100,
    S_MUL2 = 5'b01000,
    S_CMP  = 5'b10000
  } verdict_state_e;

  function automatic count_t sat_inc(input count_t v);
    return (&v) ? v : v + count_t'(1);
  endfunction

endpackage

### sv/rutd_front.sv
`timescale 1ns / 1ps
module rutd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  rutd_pkg::in_item_t in_i,
  output logic               in_stall_o,
  output logic               push_o,
  output rutd_pkg::tally_t   push_data_o,
  input  logic               full_i
);
  import rutd_pkg::*;

  sample_t prev_q, prev_d;
  logic    have_prev_q, have_prev_d;
  logic    have_dir_q, have_dir_d;
  logic    last_dir_q, last_dir_d;
  count_t  runs_q, runs_d;
  count_t  vals_q, vals_d;

  logic   take;
  logic   up;
  logic   turn;
  count_t runs_nxt;
  count_t vals_nxt;

  assign in_stall_o = full_i;
  assign take       = in_valid_i & ~full_i;

  always_comb begin
    // equal samples count as up
    up       = (prev_q <= in_i.sample);
    turn     = have_prev_q & (~have_dir_q | (up != last_dir_q));
    runs_nxt = turn ? sat_inc(runs_q) : runs_q;
    vals_nxt = sat_inc(vals_q);

    push_o             = take & in_i.last;
    push_data_o.runs   = runs_nxt;
    push_data_o.values = vals_nxt;

    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    have_dir_d  = have_dir_q;
    last_dir_d  = last_dir_q;
    runs_d      = runs_q;
    vals_d      = vals_q;
    if (take) begin
      if (in_i.last) begin
        // start a fresh sequence
        prev_d      = '0;
        have_prev_d = 1'b0;
        have_dir_d  = 1'b0;
        last_dir_d  = 1'b0;
        runs_d      = '0;
        vals_d      = '0;
      end else begin
        prev_d      = in_i.sample;
        have_prev_d = 1'b1;
        have_dir_d  = have_dir_q | have_prev_q;
        last_dir_d  = have_prev_q ? up : last_dir_q;
        runs_d      = runs_nxt;
        vals_d      = vals_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      have_dir_q  <= 1'b0;
      last_dir_q  <= 1'b0;
      runs_q      <= '0;
      vals_q      <= '0;
    end else begin
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
      have_dir_q  <= have_dir_d;
      last_dir_q  <= last_dir_d;
      runs_q      <= runs_d;
      vals_q      <= vals_d;
    end
  end

endmodule

### sv/rutd_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rutd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rutd_pkg::tally_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output rutd_pkg::tally_t head_o,
  output logic             empty_o
);
  import rutd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tally_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `RUTD_ASSERT(a_no_push_full, clk_i, rst_ni, push_i |-> !full_o, "push into full queue")
  `RUTD_ASSERT(a_no_pop_empty, clk_i, rst_ni, pop_i |-> !empty_o, "pop from empty queue")
  `RUTD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CNT_W'(DEPTH), "queue count overrun")

endmodule

### sv/rutd_verdict.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rutd_verdict (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  rutd_pkg::tally_t    head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  output rutd_pkg::out_item_t out_o,
  input  logic                out_stall_i
);
  import rutd_pkg::*;

  verdict_state_e state_q, state_d;

  count_t            r_q, r_d;
  count_t            n_q, n_d;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic              far_q, far_d;
  logic [T_W-1:0]    t_q, t_d;
  logic [P1_W-1:0]   p1_q, p1_d;
  logic [RHS_W-1:0]  rhs_q, rhs_d;
  logic [LHS_W-1:0]  lhs_q, lhs_d;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0] mag_full;
  logic              out_free;
  logic              few;

  assign pop_o       = (state_q == S_IDLE) & ~empty_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign few         = (n_q[COUNT_W-1:1] == '0);

  always_comb begin
    // d = 3R - 2N + 1, sign in the top bit
    diff     = {3'b000, r_q} + {2'b00, r_q, 1'b0} + DIFF_W'(1) - {2'b00, n_q, 1'b0};
    mag_full = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;

    state_d     = state_q;
    r_d         = r_q;
    n_d         = n_q;
    mag_d       = mag_q;
    far_d       = far_q;
    t_d         = t_q;
    p1_d        = p1_q;
    rhs_d       = rhs_q;
    lhs_d       = lhs_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          r_d     = head_i.runs;
          n_d     = head_i.values;
          state_d = S_DIFF;
        end
      end
      S_DIFF: begin
        mag_d   = mag_full[MAG_W-1:0];
        far_d   = |mag_full[DIFF_W-1:MAG_W];
        t_d     = {n_q, 4'b0000} - T_BIAS;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        p1_d    = P1_W'(mag_q) * P1_W'(LHS_K);
        rhs_d   = RHS_W'(t_q) * RHS_W'(RHS_K);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        lhs_d   = LHS_W'(p1_q) * LHS_W'(mag_q);
        state_d = S_CMP;
      end
      S_CMP: begin
        // hold until the output register frees up
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.run_count   = r_q;
          out_d.value_count = n_q;
          out_d.too_few     = few;
          out_d.accepted    = ~few & ~far_q & (lhs_q <= LHS_W'(rhs_q));
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    n_q   <= n_d;
    mag_q <= mag_d;
    far_q <= far_d;
    t_q   <= t_d;
    p1_q  <= p1_d;
    rhs_q <= rhs_d;
    lhs_q <= lhs_d;
    out_q <= out_d;
  end

  `RUTD_ASSERT(a_out_from_cmp, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_CMP), "result without compare")
  `RUTD_ASSERT(a_few_rejects, clk_i, rst_ni, out_valid_q |-> !(out_q.too_few && out_q.accepted), "too_few result accepted")
  `RUTD_ASSERT(a_diff_to_mul, clk_i, rst_ni, (state_q == S_DIFF) |=> (state_q == S_MUL1), "pipeline step skipped")

endmodule

### sv/runs_up_down_randomness_test_top.sv
// Channel  | valid        | stall        | payload (rutd_pkg)
// ---------+--------------+--------------+--------------------------------------
// in       | in_valid_i   | in_stall_o   | in_i  : in_item_t  {sample, last}
// out      | out_valid_o  | out_stall_i  | out_o : out_item_t {run_count,
//          |              |              |   value_count, accepted, too_few}
//
// Cycles: one sample request per cycle; stall rises only when the tally queue
//   holds QUEUE_DEPTH finished sequences still waiting for a verdict.
// The verdict unit steps through each sequence (pop, difference, two multiply
//   steps, compare) and pops no new one until compare is done.
// A result goes from the request marked last through the queue and the verdict
//   steps into the output register; it is taken while out_stall_i is low.
// Reset: asynchronous, active low; clears the run state, the queue and the
//   output valid flag.
// Output stall holds the result register; the verdict unit waits in compare.
`timescale 1ns / 1ps
module runs_up_down_randomness_test_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  rutd_pkg::in_item_t  in_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output rutd_pkg::out_item_t out_o,
  input  logic                out_stall_i
);
  import rutd_pkg::*;

  // front -> queue: totals of each finished sequence
  logic   push;
  tally_t push_data;
  logic   full;

  // queue -> verdict unit
  logic   pop;
  tally_t head;
  logic   empty;

  // Track direction changes and count runs and values, one sample a cycle unless the queue is full.
  rutd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Decouple the per-sample front from the multi-cycle verdict.
  rutd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  // Evaluate 6250*(3R-2N+1)^2 <= 2401*(16N-29) and drive the result register.
  rutd_verdict u_verdict (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

endmodule
